/* rtl/ckap_pkg.sv */
package ckap_pkg;

	localparam int INDEX_BITS = 16;
	localparam int COL_W      = 16;
	localparam int DATA_W     = 32;
	localparam int COEF_W     = 64;
	localparam int PROD_W     = 2 * DATA_W;
	localparam int HALF_W     = PROD_W + 1;
	localparam int SUM_W      = PROD_W + 2;
	localparam int FRAC_BITS  = 30;
	localparam int CFG_IDX_W  = 3;

	localparam logic [COL_W-1:0] COL_MASK = (INDEX_BITS >= COL_W) ? {COL_W{1'b1}} :
		COL_W'((64'd1 << INDEX_BITS) - 64'd1);

	localparam logic [CFG_IDX_W-1:0] REG_COEF_00        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_01        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_10        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_11        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_QUBIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CONTROL_ENABLE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CONTROL_QUBIT  = 3'd6;

	typedef struct packed {
		logic signed [DATA_W-1:0] re;
		logic signed [DATA_W-1:0] im;
	} cplx_t;

	typedef struct packed {
		cplx_t e;
		cplx_t p;
	} elems_t;

	typedef struct packed {
		logic             apply;
		logic [COL_W-1:0] pcol;
	} ctrl_t;

	typedef struct packed {
		cplx_t            ne;
		cplx_t            np;
		logic [COL_W-1:0] pcol;
		logic             applied;
		logic             saturated;
	} res_t;

endpackage

/* rtl/ckap_mult.sv */
module ckap_mult (
	input  logic                                     clk,
	input  logic                                     en,
	input  logic [ckap_pkg::COEF_W-1:0]              coef_00,
	input  logic [ckap_pkg::COEF_W-1:0]              coef_01,
	input  logic [ckap_pkg::COEF_W-1:0]              coef_10,
	input  logic [ckap_pkg::COEF_W-1:0]              coef_11,
	input  ckap_pkg::elems_t                         elems_s1,
	input  ckap_pkg::ctrl_t                          ctrl_s1,
	output logic signed [ckap_pkg::PROD_W-1:0]       prod_s2 [4][4],
	output ckap_pkg::elems_t                         elems_s2,
	output ckap_pkg::ctrl_t                          ctrl_s2
);

	logic signed [ckap_pkg::DATA_W-1:0] ka [4][4];
	logic signed [ckap_pkg::DATA_W-1:0] xb [4][4];
	logic signed [ckap_pkg::DATA_W-1:0] a00r, a00i, a01r, a01i, a10r, a10i, a11r, a11i;
	logic signed [ckap_pkg::DATA_W-1:0] er, ei, pr, pi;

	always_comb begin
		a00r = coef_00[31:0];
		a00i = coef_00[63:32];
		a01r = coef_01[31:0];
		a01i = coef_01[63:32];
		a10r = coef_10[31:0];
		a10i = coef_10[63:32];
		a11r = coef_11[31:0];
		a11i = coef_11[63:32];
		er = elems_s1.e.re;
		ei = elems_s1.e.im;
		pr = elems_s1.p.re;
		pi = elems_s1.p.im;
		// new elem re / im
		ka[0][0] = a00r; xb[0][0] = er;
		ka[0][1] = a00i; xb[0][1] = ei;
		ka[0][2] = a10r; xb[0][2] = pr;
		ka[0][3] = a10i; xb[0][3] = pi;
		ka[1][0] = a00r; xb[1][0] = ei;
		ka[1][1] = a00i; xb[1][1] = er;
		ka[1][2] = a10r; xb[1][2] = pi;
		ka[1][3] = a10i; xb[1][3] = pr;
		// new pair re / im
		ka[2][0] = a01r; xb[2][0] = er;
		ka[2][1] = a01i; xb[2][1] = ei;
		ka[2][2] = a11r; xb[2][2] = pr;
		ka[2][3] = a11i; xb[2][3] = pi;
		ka[3][0] = a01r; xb[3][0] = ei;
		ka[3][1] = a01i; xb[3][1] = er;
		ka[3][2] = a11r; xb[3][2] = pi;
		ka[3][3] = a11i; xb[3][3] = pr;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				for (int t = 0; t < 4; t++) begin
					prod_s2[c][t] <= ckap_pkg::PROD_W'(ka[c][t]) * ckap_pkg::PROD_W'(xb[c][t]);
				end
			end
			elems_s2 <= elems_s1;
			ctrl_s2  <= ctrl_s1;
		end
	end

endmodule

/* rtl/ckap_acc.sv */
module ckap_acc (
	input  logic                                     clk,
	input  logic                                     en_s3,
	input  logic                                     en_s4,
	input  logic signed [ckap_pkg::PROD_W-1:0]       prod_s2 [4][4],
	input  ckap_pkg::elems_t                         elems_s2,
	input  ckap_pkg::ctrl_t                          ctrl_s2,
	output ckap_pkg::res_t                           res_s4
);

	localparam logic signed [ckap_pkg::SUM_W-1:0] HALF_LSB =
		ckap_pkg::SUM_W'(64'sd1 <<< (ckap_pkg::FRAC_BITS - 1));
	localparam logic signed [ckap_pkg::SUM_W-1:0] MAX_Q = ckap_pkg::SUM_W'(64'sd2147483647);
	localparam logic signed [ckap_pkg::SUM_W-1:0] MIN_Q = ckap_pkg::SUM_W'(-64'sd2147483648);

	logic signed [ckap_pkg::HALF_W-1:0] half_s3 [4][2];
	ckap_pkg::elems_t                   elems_s3;
	ckap_pkg::ctrl_t                    ctrl_s3;

	logic signed [ckap_pkg::SUM_W-1:0]  sum [4];
	logic signed [ckap_pkg::SUM_W-1:0]  q [4];
	logic signed [ckap_pkg::DATA_W-1:0] val [4];
	logic [3:0]                         clip;

	// real parts subtract the imag*imag terms
	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int c = 0; c < 4; c++) begin
				if (c == 0 || c == 2) begin
					half_s3[c][0] <= ckap_pkg::HALF_W'(prod_s2[c][0]) -
						ckap_pkg::HALF_W'(prod_s2[c][1]);
					half_s3[c][1] <= ckap_pkg::HALF_W'(prod_s2[c][2]) -
						ckap_pkg::HALF_W'(prod_s2[c][3]);
				end else begin
					half_s3[c][0] <= ckap_pkg::HALF_W'(prod_s2[c][0]) +
						ckap_pkg::HALF_W'(prod_s2[c][1]);
					half_s3[c][1] <= ckap_pkg::HALF_W'(prod_s2[c][2]) +
						ckap_pkg::HALF_W'(prod_s2[c][3]);
				end
			end
			elems_s3 <= elems_s2;
			ctrl_s3  <= ctrl_s2;
		end
	end

	// round half up, then clip to 32 bits
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			sum[c] = ckap_pkg::SUM_W'(half_s3[c][0]) + ckap_pkg::SUM_W'(half_s3[c][1]) + HALF_LSB;
			q[c]   = sum[c] >>> ckap_pkg::FRAC_BITS;
			if (q[c] > MAX_Q) begin
				val[c]  = ckap_pkg::DATA_W'(MAX_Q);
				clip[c] = 1'b1;
			end else if (q[c] < MIN_Q) begin
				val[c]  = ckap_pkg::DATA_W'(MIN_Q);
				clip[c] = 1'b1;
			end else begin
				val[c]  = q[c][ckap_pkg::DATA_W-1:0];
				clip[c] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			res_s4.pcol    <= ctrl_s3.pcol;
			res_s4.applied <= ctrl_s3.apply;
			if (ctrl_s3.apply) begin
				res_s4.ne.re     <= val[0];
				res_s4.ne.im     <= val[1];
				res_s4.np.re     <= val[2];
				res_s4.np.im     <= val[3];
				res_s4.saturated <= |clip;
			end else begin
				res_s4.ne        <= elems_s3.e;
				res_s4.np        <= elems_s3.p;
				res_s4.saturated <= 1'b0;
			end
		end
	end

endmodule

/* rtl/controlled_2x2_complex_kernel_apply_top.sv */
// An accepted transaction passes the input, multiply, partial-sum and result registers to reach the output.
// Throughput: one transaction per cycle while out_ready does not stall it; set by the four-stage multiply/add pipeline.
// Each stage holds when the next is full and stalled; bubbles are filled on a stall.
// Reset (arst_n low, asynchronous): pipeline emptied, kernel set to identity,
// target and control qubit 0, control disabled.
module controlled_2x2_complex_kernel_apply_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [ckap_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ckap_pkg::COEF_W-1:0]           cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [ckap_pkg::COL_W-1:0]            column_index,
	input  logic signed [ckap_pkg::DATA_W-1:0]    elem_re,
	input  logic signed [ckap_pkg::DATA_W-1:0]    elem_im,
	input  logic signed [ckap_pkg::DATA_W-1:0]    pair_re,
	input  logic signed [ckap_pkg::DATA_W-1:0]    pair_im,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [ckap_pkg::DATA_W-1:0]    new_elem_re,
	output logic signed [ckap_pkg::DATA_W-1:0]    new_elem_im,
	output logic signed [ckap_pkg::DATA_W-1:0]    new_pair_re,
	output logic signed [ckap_pkg::DATA_W-1:0]    new_pair_im,
	output logic [ckap_pkg::COL_W-1:0]            pair_column,
	output logic                                  applied,
	output logic                                  saturated
);

	localparam logic [ckap_pkg::COEF_W-1:0] ONE_Q30 = ckap_pkg::COEF_W'(64'd1073741824);

	logic [ckap_pkg::COEF_W-1:0] coef_00_q, coef_01_q, coef_10_q, coef_11_q;
	logic [3:0]                  target_qubit_q;
	logic                        control_enable_q;
	logic [3:0]                  control_qubit_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	ckap_pkg::elems_t elems_s1, elems_s2;
	ckap_pkg::ctrl_t  ctrl_s1, ctrl_s2;
	ckap_pkg::res_t   res_s4;
	logic signed [ckap_pkg::PROD_W-1:0] prod_s2 [4][4];

	logic [ckap_pkg::COL_W-1:0] col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_00_q        <= ONE_Q30;
			coef_01_q        <= '0;
			coef_10_q        <= '0;
			coef_11_q        <= ONE_Q30;
			target_qubit_q   <= '0;
			control_enable_q <= 1'b0;
			control_qubit_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ckap_pkg::REG_COEF_00:        coef_00_q        <= cfg_data;
				ckap_pkg::REG_COEF_01:        coef_01_q        <= cfg_data;
				ckap_pkg::REG_COEF_10:        coef_10_q        <= cfg_data;
				ckap_pkg::REG_COEF_11:        coef_11_q        <= cfg_data;
				ckap_pkg::REG_TARGET_QUBIT:   target_qubit_q   <= cfg_data[3:0];
				ckap_pkg::REG_CONTROL_ENABLE: control_enable_q <= cfg_data[0];
				ckap_pkg::REG_CONTROL_QUBIT:  control_qubit_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	assign col = column_index & ckap_pkg::COL_MASK;

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			elems_s1.e.re <= elem_re;
			elems_s1.e.im <= elem_im;
			elems_s1.p.re <= pair_re;
			elems_s1.p.im <= pair_im;
			ctrl_s1.pcol  <= (col + (ckap_pkg::COL_W'(1) << target_qubit_q)) &
				ckap_pkg::COL_MASK;
			ctrl_s1.apply <= !control_enable_q || col[control_qubit_q];
		end
	end

	ckap_mult u_mult (
		.clk      (clk),
		.en       (rdy2 && v_s1),
		.coef_00  (coef_00_q),
		.coef_01  (coef_01_q),
		.coef_10  (coef_10_q),
		.coef_11  (coef_11_q),
		.elems_s1 (elems_s1),
		.ctrl_s1  (ctrl_s1),
		.prod_s2  (prod_s2),
		.elems_s2 (elems_s2),
		.ctrl_s2  (ctrl_s2)
	);

	ckap_acc u_acc (
		.clk      (clk),
		.en_s3    (rdy3 && v_s2),
		.en_s4    (rdy4 && v_s3),
		.prod_s2  (prod_s2),
		.elems_s2 (elems_s2),
		.ctrl_s2  (ctrl_s2),
		.res_s4   (res_s4)
	);

	assign out_valid   = v_s4;
	assign new_elem_re = res_s4.ne.re;
	assign new_elem_im = res_s4.ne.im;
	assign new_pair_re = res_s4.np.re;
	assign new_pair_im = res_s4.np.im;
	assign pair_column = res_s4.pcol;
	assign applied     = res_s4.applied;
	assign saturated   = res_s4.saturated;

endmodule

/* tb/sv/controlled_2x2_complex_kernel_apply_top_test.sv */
`timescale 1ns / 100ps

module controlled_2x2_complex_kernel_apply_top_test;

	localparam int PIPE_LAT    = 3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int BLOCK_ITEMS = 87;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t                          kind;
		logic [ckap_pkg::CFG_IDX_W-1:0]     reg_idx;
		logic [ckap_pkg::COEF_W-1:0]        reg_val;
		logic [ckap_pkg::COL_W-1:0]         col;
		logic signed [ckap_pkg::DATA_W-1:0] er;
		logic signed [ckap_pkg::DATA_W-1:0] ei;
		logic signed [ckap_pkg::DATA_W-1:0] pr;
		logic signed [ckap_pkg::DATA_W-1:0] pi;
		bit                                 typed;
		ckap_pkg::res_t                     want;
	} stim_row_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               cfg_wr_en = 1'b0;
	logic [ckap_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
	logic [ckap_pkg::COEF_W-1:0]        cfg_data = '0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic [ckap_pkg::COL_W-1:0]         column_index = '0;
	logic signed [ckap_pkg::DATA_W-1:0] elem_re = '0;
	logic signed [ckap_pkg::DATA_W-1:0] elem_im = '0;
	logic signed [ckap_pkg::DATA_W-1:0] pair_re = '0;
	logic signed [ckap_pkg::DATA_W-1:0] pair_im = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic signed [ckap_pkg::DATA_W-1:0] new_elem_re;
	logic signed [ckap_pkg::DATA_W-1:0] new_elem_im;
	logic signed [ckap_pkg::DATA_W-1:0] new_pair_re;
	logic signed [ckap_pkg::DATA_W-1:0] new_pair_im;
	logic [ckap_pkg::COL_W-1:0]         pair_column;
	logic                               applied;
	logic                               saturated;

	// shadow of the block's registers
	logic [ckap_pkg::COEF_W-1:0] kern [4];
	logic [3:0]                  tgt_q;
	logic                        ctl_on;
	logic [3:0]                  ctl_q;

	ckap_pkg::res_t pending_results[$];
	stim_row_t directed_rows[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;
	int sent_items = 0;
	int checked = 0;
	int passed_through = 0;
	int clipped_results = 0;
	int reg_writes = 0;
	int cycle_count = 0;

	controlled_2x2_complex_kernel_apply_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.column_index (column_index),
		.elem_re      (elem_re),
		.elem_im      (elem_im),
		.pair_re      (pair_re),
		.pair_im      (pair_im),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.new_elem_re  (new_elem_re),
		.new_elem_im  (new_elem_im),
		.new_pair_re  (new_pair_re),
		.new_pair_im  (new_pair_im),
		.pair_column  (pair_column),
		.applied      (applied),
		.saturated    (saturated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// exact sum rounded half up to Q1.30, then clipped to 32 bits
	function automatic logic signed [ckap_pkg::DATA_W-1:0] q30_round(
			input logic signed [127:0] acc, inout bit clipped);
		logic signed [127:0] r;
		r = (acc + 128'sd536870912) >>> ckap_pkg::FRAC_BITS;
		if (r > 128'sd2147483647) begin
			clipped = 1'b1;
			return 32'sh7FFFFFFF;
		end
		if (r < -128'sd2147483648) begin
			clipped = 1'b1;
			return 32'sh80000000;
		end
		return r[ckap_pkg::DATA_W-1:0];
	endfunction

	function automatic ckap_pkg::res_t kernel_result(input logic [ckap_pkg::COL_W-1:0] col,
			input logic signed [ckap_pkg::DATA_W-1:0] er, ei, pr, pi);
		ckap_pkg::res_t             r;
		logic [ckap_pkg::COL_W-1:0] c;
		logic signed [127:0]        ar [4];
		logic signed [127:0]        ai [4];
		logic signed [127:0]        xr, xi, yr, yi;
		bit                         clipped;
		c = col & ckap_pkg::COL_MASK;
		r.pcol = (c + (16'd1 << tgt_q)) & ckap_pkg::COL_MASK;
		if (ctl_on && !c[ctl_q]) begin
			r.ne = '{er, ei};
			r.np = '{pr, pi};
			r.applied = 1'b0;
			r.saturated = 1'b0;
			return r;
		end
		for (int k = 0; k < 4; k++) begin
			ar[k] = $signed(kern[k][31:0]);
			ai[k] = $signed(kern[k][63:32]);
		end
		xr = er;
		xi = ei;
		yr = pr;
		yi = pi;
		clipped = 1'b0;
		r.ne.re = q30_round(ar[0] * xr - ai[0] * xi + ar[2] * yr - ai[2] * yi, clipped);
		r.ne.im = q30_round(ar[0] * xi + ai[0] * xr + ar[2] * yi + ai[2] * yr, clipped);
		r.np.re = q30_round(ar[1] * xr - ai[1] * xi + ar[3] * yr - ai[3] * yi, clipped);
		r.np.im = q30_round(ar[1] * xi + ai[1] * xr + ar[3] * yi + ai[3] * yr, clipped);
		r.applied = 1'b1;
		r.saturated = clipped;
		return r;
	endfunction

	function automatic ckap_pkg::res_t outcome(
			input logic signed [ckap_pkg::DATA_W-1:0] ner, nei, npr, npi,
			input logic [ckap_pkg::COL_W-1:0] pcol, input logic app, input logic sat);
		ckap_pkg::res_t r;
		r.ne = '{ner, nei};
		r.np = '{npr, npi};
		r.pcol = pcol;
		r.applied = app;
		r.saturated = sat;
		return r;
	endfunction

	function automatic stim_row_t item_row(input logic [ckap_pkg::COL_W-1:0] col,
			input logic signed [ckap_pkg::DATA_W-1:0] er, ei, pr, pi);
		stim_row_t r;
		r.kind = ROW_ITEM;
		r.reg_idx = '0;
		r.reg_val = '0;
		r.col = col;
		r.er = er;
		r.ei = ei;
		r.pr = pr;
		r.pi = pi;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t typed_row(input logic [ckap_pkg::COL_W-1:0] col,
			input logic signed [ckap_pkg::DATA_W-1:0] er, ei, pr, pi,
			input ckap_pkg::res_t want);
		stim_row_t r;
		r = item_row(col, er, ei, pr, pi);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic stim_row_t reg_row(input logic [ckap_pkg::CFG_IDX_W-1:0] idx,
			input logic [ckap_pkg::COEF_W-1:0] val);
		stim_row_t r;
		r = item_row('0, '0, '0, '0, '0);
		r.kind = ROW_REG;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic void add_row(input stim_row_t r);
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	function automatic logic [ckap_pkg::DATA_W-1:0] rand_coef_part();
		logic [ckap_pkg::DATA_W-1:0] v;
		v = $urandom;
		case ($urandom_range(5))
			0: return 32'h80000000;
			1: return 32'h7FFFFFFF;
			2: return 32'h0;
			3, 4: return {{2{v[29]}}, v[29:0]};
			default: return v;
		endcase
	endfunction

	function automatic logic signed [ckap_pkg::DATA_W-1:0] rand_elem();
		logic [ckap_pkg::DATA_W-1:0] v;
		v = $urandom;
		case ($urandom_range(5))
			0: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
			1, 2, 3: return $signed({{3{v[28]}}, v[28:0]});
			default: return $signed(v);
		endcase
	endfunction

	task automatic write_reg(input logic [ckap_pkg::CFG_IDX_W-1:0] idx,
			input logic [ckap_pkg::COEF_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			ckap_pkg::REG_COEF_00, ckap_pkg::REG_COEF_01,
			ckap_pkg::REG_COEF_10, ckap_pkg::REG_COEF_11: kern[idx[1:0]] = val;
			ckap_pkg::REG_TARGET_QUBIT: tgt_q = val[3:0];
			ckap_pkg::REG_CONTROL_ENABLE: ctl_on = val[0];
			ckap_pkg::REG_CONTROL_QUBIT: ctl_q = val[3:0];
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// hold off the sender until every outstanding transaction has come back
	task automatic settle();
		if (in_valid)
			in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	task automatic send_item(input logic [ckap_pkg::COL_W-1:0] col,
			input logic signed [ckap_pkg::DATA_W-1:0] er, ei, pr, pi, input bit typed,
			input ckap_pkg::res_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		column_index <= col;
		elem_re <= er;
		elem_im <= ei;
		pair_re <= pr;
		pair_im <= pi;
		do
			@(posedge clk);
		while (!in_ready);
		pending_results.insert(pending_results.size(),
			typed ? want : kernel_result(col, er, ei, pr, pi));
		sent_items++;
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin : check_results
		ckap_pkg::res_t got;
		ckap_pkg::res_t want;
		if (arst_n && out_valid && out_ready) begin
			got = outcome(new_elem_re, new_elem_im, new_pair_re, new_pair_im, pair_column,
				applied, saturated);
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result ne=%h/%h np=%h/%h col=%h", $time,
						got.ne.re, got.ne.im, got.np.re, got.np.im, got.pcol);
			end else begin
				want = pending_results.pop_front();
				checked++;
				if (!got.applied)
					passed_through++;
				if (got.saturated)
					clipped_results++;
				if (got.ne.re !== want.ne.re || got.ne.im !== want.ne.im ||
						got.np.re !== want.np.re || got.np.im !== want.np.im ||
						got.pcol !== want.pcol || got.applied !== want.applied ||
						got.saturated !== want.saturated) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: mismatch on transaction %0d", $time, checked);
						$display("  want ne=%h/%h np=%h/%h col=%h app=%b sat=%b",
							want.ne.re, want.ne.im, want.np.re, want.np.im, want.pcol,
							want.applied, want.saturated);
						$display("  got  ne=%h/%h np=%h/%h col=%h app=%b sat=%b",
							got.ne.re, got.ne.im, got.np.re, got.np.im, got.pcol,
							got.applied, got.saturated);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out with %0d results outstanding", pending_results.size());
			$display("controlled_2x2_complex_kernel_apply_top_test NOT OK");
			$finish;
		end
	end

	initial begin
		kern[0] = 64'h0000_0000_4000_0000;
		kern[1] = '0;
		kern[2] = '0;
		kern[3] = 64'h0000_0000_4000_0000;
		tgt_q = '0;
		ctl_on = 1'b0;
		ctl_q = '0;

		// identity kernel after reset
		add_row(typed_row(16'h0000, 32'h0, 32'h0, 32'h0, 32'h0,
			outcome(32'h0, 32'h0, 32'h0, 32'h0, 16'h0001, 1'b1, 1'b0)));
		add_row(typed_row(16'hFFFF, 32'h7FFFFFFF, 32'h80000000,
			32'h80000000, 32'h7FFFFFFF, outcome(32'h7FFFFFFF, 32'h80000000,
			32'h80000000, 32'h7FFFFFFF, 16'h0000, 1'b1, 1'b0)));
		// minus one: most negative input clips high
		add_row(reg_row(ckap_pkg::REG_COEF_00, 64'h0000_0000_C000_0000));
		add_row(typed_row(16'h0002, 32'h80000000, 32'h7FFFFFFF,
			32'h00000005, 32'hFFFFFFFB, outcome(32'h7FFFFFFF, 32'h80000001,
			32'h00000005, 32'hFFFFFFFB, 16'h0003, 1'b1, 1'b1)));
		add_row(reg_row(ckap_pkg::REG_COEF_00, 64'h0000_0000_7FFF_FFFF));
		add_row(item_row(16'h0004, 32'h80000000, 32'h40000000,
			32'h7FFFFFFF, 32'h80000000));
		add_row(reg_row(ckap_pkg::REG_COEF_00, 64'h8000_0000_8000_0000));
		add_row(reg_row(ckap_pkg::REG_COEF_01, 64'h7FFF_FFFF_8000_0000));
		add_row(reg_row(ckap_pkg::REG_COEF_10, 64'h8000_0000_7FFF_FFFF));
		add_row(reg_row(ckap_pkg::REG_COEF_11, 64'h7FFF_FFFF_7FFF_FFFF));
		add_row(item_row(16'h5555, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000));
		add_row(item_row(16'hAAAA, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF));
		add_row(item_row(16'h00FF, 32'h80000000, 32'h7FFFFFFF,
			32'h00000001, 32'hFFFFFFFF));
		// halves: rounding ties
		add_row(reg_row(ckap_pkg::REG_COEF_00, 64'h0000_0000_2000_0000));
		add_row(reg_row(ckap_pkg::REG_COEF_01, 64'h0));
		add_row(reg_row(ckap_pkg::REG_COEF_10, 64'h0));
		add_row(reg_row(ckap_pkg::REG_COEF_11, 64'h2000_0000_0000_0000));
		add_row(item_row(16'h0010, 32'h00000001, 32'hFFFFFFFF,
			32'h00000003, 32'hFFFFFFFD));
		// top target bit: pair column wraps, target bit already set
		add_row(reg_row(ckap_pkg::REG_TARGET_QUBIT, 64'd15));
		add_row(item_row(16'h8000, 32'h12345678, 32'h9ABCDEF0,
			32'h0F0F0F0F, 32'hF0F0F0F0));
		add_row(reg_row(ckap_pkg::REG_CONTROL_ENABLE, 64'd1));
		add_row(reg_row(ckap_pkg::REG_CONTROL_QUBIT, 64'd15));
		add_row(typed_row(16'h7FFF, 32'h12345678, 32'h87654321,
			32'h00000001, 32'h80000000, outcome(32'h12345678, 32'h87654321,
			32'h00000001, 32'h80000000, 16'hFFFF, 1'b0, 1'b0)));
		add_row(item_row(16'h8001, 32'h3FFFFFFF, 32'hC0000000,
			32'h7FFFFFFF, 32'h00000001));
		add_row(reg_row(ckap_pkg::REG_CONTROL_QUBIT, 64'd0));
		add_row(item_row(16'h0001, 32'hC0000001, 32'h40000000,
			32'h80000001, 32'h7FFFFFFE));
		add_row(typed_row(16'hFFFE, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, 32'h80000000, outcome(32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, 32'h80000000, 16'h7FFE, 1'b0, 1'b0)));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 33;
		recv_idle_pct = 65;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REG) begin
				settle();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
			end else begin
				send_item(directed_rows[i].col, directed_rows[i].er, directed_rows[i].ei,
					directed_rows[i].pr, directed_rows[i].pi, directed_rows[i].typed,
					directed_rows[i].want);
			end
		end

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 65 : 0;
			recv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 33 : 0;
			for (int blk = 0; blk < 4; blk++) begin
				settle();
				for (int k = 0; k < 4; k++)
					write_reg(ckap_pkg::CFG_IDX_W'(ckap_pkg::REG_COEF_00 + k),
						{rand_coef_part(), rand_coef_part()});
				write_reg(ckap_pkg::REG_TARGET_QUBIT, 64'($urandom_range(15)));
				write_reg(ckap_pkg::REG_CONTROL_ENABLE, 64'($urandom_range(1)));
				write_reg(ckap_pkg::REG_CONTROL_QUBIT, 64'($urandom_range(15)));
				repeat (BLOCK_ITEMS)
					send_item(16'($urandom_range(16'hFFFF)), rand_elem(), rand_elem(),
						rand_elem(), rand_elem(), 1'b0, '0);
			end
		end

		settle();
		$display("Checked %0d results from %0d transactions over %0d register writes",
			checked, sent_items, reg_writes);
		$display("%0d passed through, %0d saturated, %0d mismatching",
			passed_through, clipped_results, mismatches);
		if (mismatches == 0)
			$display("controlled_2x2_complex_kernel_apply_top_test OK");
		else
			$display("controlled_2x2_complex_kernel_apply_top_test NOT OK");
		$finish;
	end

endmodule
